### src/swoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swoc_pkg
// Shared types, widths and codes of the sliding-window candle unit.
// ----------------------------------------------------------------------------
package swoc_pkg;

  localparam int HISTORY_DEPTH = 1024;
  localparam int HIST_LOG      = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = HIST_LOG + 1;
  localparam int VOL_W         = 24 + HIST_LOG;
  localparam int ACC_W         = 56 + HIST_LOG;
  localparam int DVD_W         = ACC_W + 1;
  localparam int DIV_CNT_W     = $clog2(DVD_W + 1);

  // candle kinds
  localparam logic [1:0] WIN_MAIN = 2'd0;
  localparam logic [1:0] WIN_GAIN = 2'd1;
  localparam logic [1:0] WIN_LOSS = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MAIN_WINDOW = 2'd0;
  localparam logic [1:0] REG_GAIN_WINDOW = 2'd1;
  localparam logic [1:0] REG_LOSS_WINDOW = 2'd2;

  typedef struct packed {
    logic [31:0] time_stamp;
    logic [31:0] price;
    logic [23:0] quantity;
  } entry_t;

  typedef struct packed {
    logic load;    // shift a new trade in from the head side
    logic rotate;  // pass entries one place toward the head
  } cell_ctrl_t;

  typedef struct packed {
    logic [31:0]      open;
    logic [31:0]      high;
    logic [31:0]      low;
    logic [VOL_W-1:0] vol;
    logic [CNT_W-1:0] cnt;
    logic             stop;
  } win_acc_t;

endpackage

### src/trade_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trade_if
// Request channel carrying one trade.
// ----------------------------------------------------------------------------
interface trade_if;
  logic        valid;
  logic        ready;
  logic [31:0] trade_time;
  logic [31:0] trade_price;
  logic [23:0] trade_quantity;

  modport source (output valid, output trade_time, output trade_price,
                  output trade_quantity, input ready);
  modport sink   (input valid, input trade_time, input trade_price,
                  input trade_quantity, output ready);
endinterface

### src/candle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// candle_if
// Request channel carrying one candle.
// ----------------------------------------------------------------------------
interface candle_if;
  logic               valid;
  logic               ready;
  logic [1:0]         which_window;
  logic [31:0]        open_price;
  logic [31:0]        high_price;
  logic [31:0]        low_price;
  logic [31:0]        close_price;
  logic [31:0]        close_stamp;
  logic [33:0]        volume;
  logic [10:0]        trade_count;
  logic [31:0]        mean_price;
  logic               mean_valid;
  logic signed [32:0] prior_sequence;
  logic               is_last;

  modport source (output valid, output which_window, output open_price,
                  output high_price, output low_price, output close_price,
                  output close_stamp, output volume, output trade_count,
                  output mean_price, output mean_valid, output prior_sequence,
                  output is_last, input ready);
  modport sink   (input valid, input which_window, input open_price,
                  input high_price, input low_price, input close_price,
                  input close_stamp, input volume, input trade_count,
                  input mean_price, input mean_valid, input prior_sequence,
                  input is_last, output ready);
endinterface

### src/swoc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swoc_cell
// One history slot: loads from its head-side neighbor, rotates from its tail side.
// ----------------------------------------------------------------------------
module swoc_cell (
  input  logic                 clk,
  input  swoc_pkg::cell_ctrl_t ctrl,
  input  swoc_pkg::entry_t     from_head,
  input  swoc_pkg::entry_t     from_tail,
  output swoc_pkg::entry_t     q
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= from_head;
    end else if (ctrl.rotate) begin
      q <= from_tail;
    end
  end

endmodule

### src/swoc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swoc_div
// Restoring divider, one quotient bit per cycle; keeps the low 32 quotient bits.
// ----------------------------------------------------------------------------
module swoc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [swoc_pkg::DVD_W-1:0] dividend,
  input  logic [swoc_pkg::VOL_W-1:0] divisor,
  output logic                       busy,
  output logic [31:0]                quotient
);

  logic [swoc_pkg::DVD_W-1:0]     dvd;
  logic [swoc_pkg::VOL_W-1:0]     den;
  logic [swoc_pkg::VOL_W:0]       rem;
  logic [swoc_pkg::DIV_CNT_W-1:0] cnt;
  logic [swoc_pkg::VOL_W+1:0]     trial;
  logic                           fits;

  assign trial = {rem, dvd[swoc_pkg::DVD_W-1]};
  assign fits  = trial >= {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= swoc_pkg::DIV_CNT_W'(swoc_pkg::DVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == swoc_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[swoc_pkg::DVD_W-2:0], 1'b0};
      rem      <= fits ? (swoc_pkg::VOL_W+1)'(trial - {2'b00, den})
                       : (swoc_pkg::VOL_W+1)'(trial);
      quotient <= {quotient[30:0], fits};
    end
  end

endmodule

### src/sliding_window_ohlc_candle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_ohlc_candle
// Trade history in a ring of cells; a main candle per trade, plus gain and loss candles when their window is nonzero.
// ----------------------------------------------------------------------------
// Channel   | Dir | Handshake     | Payload
// trade     | in  | valid / ready | trade_time, trade_price, trade_quantity
// candle    | out | valid / ready | which_window .. is_last (one candle)
// config    | in  | write_enable  | write_index, write_data
//
// After a trade is taken, the walk rotates the whole cell ring once, one
// entry per cycle, and the shared-nothing dividers then work through the
// dividend bit by bit; the candles are then offered one after another as
// the receiver takes them. Reset clears control state only; the ring needs
// no clearing pass since the fill count guards it. A stalled candle holds
// its payload; no trade is taken until the last candle leaves.
// ----------------------------------------------------------------------------
module sliding_window_ohlc_candle (
  input  logic        clk,
  input  logic        rst,
  trade_if.sink       trade,
  candle_if.source    candle,
  input  logic        write_enable,
  input  logic [1:0]  write_index,
  input  logic [31:0] write_data
);

  localparam int D = swoc_pkg::HISTORY_DEPTH;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state;

  // configuration
  logic [31:0] main_window;
  logic [31:0] gain_window;
  logic [31:0] loss_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_window <= 32'd60;
      gain_window <= '0;
      loss_window <= '0;
    end else if (write_enable) begin
      case (write_index)
        swoc_pkg::REG_MAIN_WINDOW: main_window <= write_data;
        swoc_pkg::REG_GAIN_WINDOW: gain_window <= write_data;
        swoc_pkg::REG_LOSS_WINDOW: loss_window <= write_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Cell ring: cell 0 is the newest trade. Rotating moves every entry one
  // place toward cell 0, so cell 1 shows the k-th older trade at walk step k;
  // a full turn of D steps puts the ring back in place.
  // --------------------------------------------------------------------------
  logic                 accept;
  swoc_pkg::cell_ctrl_t ctrl;
  swoc_pkg::entry_t     new_entry;
  swoc_pkg::entry_t     cells [D];

  assign accept = trade.valid && trade.ready;
  assign ctrl.load   = accept;
  assign ctrl.rotate = (state == ST_WALK);
  assign new_entry = '{time_stamp: trade.trade_time, price: trade.trade_price,
                       quantity: trade.trade_quantity};

  for (genvar i = 0; i < D; i++) begin : g_cell
    swoc_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .from_head ((i == 0) ? new_entry : cells[(i + D - 1) % D]),
      .from_tail (cells[(i + 1) % D]),
      .q         (cells[i])
    );
  end

  // --------------------------------------------------------------------------
  // Walk over the history
  // --------------------------------------------------------------------------
  logic [swoc_pkg::CNT_W-1:0] fill;
  logic [swoc_pkg::CNT_W-1:0] step;
  logic [31:0]                seq;
  logic [31:0]                newest_time;
  logic [31:0]                newest_price;

  swoc_pkg::win_acc_t         wacc [3];
  logic [swoc_pkg::ACC_W-1:0] acc_main;
  logic [swoc_pkg::ACC_W-1:0] acc_gain;
  logic [55:0]                prod;
  logic                       pend_main;
  logic                       pend_gain;

  swoc_pkg::entry_t tap;
  logic [32:0]      age;
  logic             step_ok;
  logic [31:0]      win_len [3];
  logic [2:0]       in_win;

  assign tap     = cells[1];
  assign age     = {1'b0, newest_time} - {1'b0, tap.time_stamp};
  assign step_ok = step < fill;
  assign win_len[0] = main_window;
  assign win_len[1] = gain_window;
  assign win_len[2] = loss_window;

  // a stored time later than the newest counts as inside every window
  always_comb begin
    for (int w = 0; w < 3; w++) begin
      in_win[w] = step_ok && !wacc[w].stop && (age[32] || (age[31:0] <= win_len[w]));
    end
  end

  // product of the trade being looked at, registered and added in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      prod <= trade.trade_price * trade.trade_quantity;
    end else begin
      prod <= tap.price * tap.quantity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_main <= 1'b0;
      pend_gain <= 1'b0;
    end else if (accept) begin
      pend_main <= 1'b1;
      pend_gain <= 1'b1;
    end else if (state == ST_WALK) begin
      pend_main <= in_win[0];
      pend_gain <= in_win[1];
    end else begin
      pend_main <= 1'b0;
      pend_gain <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_main <= '0;
      acc_gain <= '0;
    end else begin
      if (pend_main) acc_main <= acc_main + swoc_pkg::ACC_W'(prod);
      if (pend_gain) acc_gain <= acc_gain + swoc_pkg::ACC_W'(prod);
    end
  end

  // open, high, low, volume and count per window
  always_ff @(posedge clk) begin
    for (int w = 0; w < 3; w++) begin
      if (accept) begin
        wacc[w].open <= trade.trade_price;
        wacc[w].high <= trade.trade_price;
        wacc[w].low  <= trade.trade_price;
        wacc[w].vol  <= swoc_pkg::VOL_W'(trade.trade_quantity);
        wacc[w].cnt  <= swoc_pkg::CNT_W'(1);
        wacc[w].stop <= 1'b0;
      end else if (state == ST_WALK) begin
        if (in_win[w]) begin
          wacc[w].open <= tap.price;
          if (tap.price > wacc[w].high) wacc[w].high <= tap.price;
          if (tap.price < wacc[w].low)  wacc[w].low  <= tap.price;
          wacc[w].vol <= wacc[w].vol + swoc_pkg::VOL_W'(tap.quantity);
          wacc[w].cnt <= wacc[w].cnt + 1'b1;
        end else begin
          wacc[w].stop <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      newest_time  <= trade.trade_time;
      newest_price <= trade.trade_price;
    end
  end

  // --------------------------------------------------------------------------
  // Weighted mean: rounded (acc + vol/2) / vol for main and gain candles
  // --------------------------------------------------------------------------
  logic        div_start;
  logic        busy_main;
  logic        busy_gain;
  logic [31:0] quot_main;
  logic [31:0] quot_gain;

  assign div_start = (state == ST_START);

  swoc_div u_div_main (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (swoc_pkg::DVD_W'(acc_main) + swoc_pkg::DVD_W'(wacc[0].vol >> 1)),
    .divisor  (wacc[0].vol),
    .busy     (busy_main),
    .quotient (quot_main)
  );

  swoc_div u_div_gain (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (swoc_pkg::DVD_W'(acc_gain) + swoc_pkg::DVD_W'(wacc[1].vol >> 1)),
    .divisor  (wacc[1].vol),
    .busy     (busy_gain),
    .quotient (quot_gain)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [1:0] sel;
  logic       last_cand;

  always_comb begin
    case (sel)
      swoc_pkg::WIN_MAIN: last_cand = (gain_window == '0) && (loss_window == '0);
      swoc_pkg::WIN_GAIN: last_cand = (loss_window == '0);
      default:            last_cand = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      step  <= '0;
      seq   <= '0;
      sel   <= swoc_pkg::WIN_MAIN;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (fill < swoc_pkg::CNT_W'(D)) fill <= fill + 1'b1;
            step  <= swoc_pkg::CNT_W'(1);
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          step <= step + 1'b1;
          if (step == swoc_pkg::CNT_W'(D)) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (!busy_main && !busy_gain) begin
            sel   <= swoc_pkg::WIN_MAIN;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (candle.ready) begin
            if (last_cand) begin
              seq   <= seq + 1'b1;
              state <= ST_IDLE;
            end else if (sel == swoc_pkg::WIN_MAIN && gain_window != '0) begin
              sel <= swoc_pkg::WIN_GAIN;
            end else begin
              sel <= swoc_pkg::WIN_LOSS;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Candle payload, selected from held registers
  // --------------------------------------------------------------------------
  swoc_pkg::win_acc_t cur;
  logic [31:0]        quot;
  logic [31:0]        start_seq;

  assign cur       = (sel == swoc_pkg::WIN_MAIN) ? wacc[0] :
                     (sel == swoc_pkg::WIN_GAIN) ? wacc[1] : wacc[2];
  assign quot      = (sel == swoc_pkg::WIN_MAIN) ? quot_main : quot_gain;
  assign start_seq = seq - 32'(cur.cnt - 1'b1);

  assign trade.ready           = (state == ST_IDLE);
  assign candle.valid          = (state == ST_EMIT);
  assign candle.which_window   = sel;
  assign candle.open_price     = cur.open;
  assign candle.high_price     = cur.high;
  assign candle.low_price      = cur.low;
  assign candle.close_price    = newest_price;
  assign candle.close_stamp    = newest_time;
  assign candle.volume         = 34'(cur.vol);
  assign candle.trade_count    = 11'(cur.cnt);
  assign candle.mean_valid     = (sel != swoc_pkg::WIN_LOSS) && (cur.vol != '0);
  assign candle.mean_price     = candle.mean_valid ? quot : 32'd0;
  assign candle.prior_sequence = (start_seq == 32'd0) ? -33'sd1
                                                      : $signed({1'b0, start_seq - 32'd1});
  assign candle.is_last        = last_cand;

endmodule

### dv/candle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// candle_checker
// Watches the trade, candle and register channels, predicts every candle from
// its own copy of the trade history and compares the candles field by field.
// ----------------------------------------------------------------------------
module candle_checker (
  input  logic        clk,
  input  logic        rst,
  trade_if            trade,
  candle_if           candle,
  input  logic        write_enable,
  input  logic [1:0]  write_index,
  input  logic [31:0] write_data,
  output int          fail_count,
  output int          pending,
  output int          trades_seen,
  output int          candles_seen
);

  typedef struct {
    logic [1:0]         which_window;
    logic [31:0]        open_price;
    logic [31:0]        high_price;
    logic [31:0]        low_price;
    logic [31:0]        close_price;
    logic [31:0]        close_stamp;
    logic [33:0]        volume;
    logic [10:0]        trade_count;
    logic [31:0]        mean_price;
    logic               mean_valid;
    logic signed [32:0] prior_sequence;
    logic               is_last;
  } candle_t;

  logic [31:0] win_main, win_gain, win_loss;
  logic [31:0] ring_time [swoc_pkg::HISTORY_DEPTH];
  logic [31:0] ring_price[swoc_pkg::HISTORY_DEPTH];
  logic [23:0] ring_qty  [swoc_pkg::HISTORY_DEPTH];
  int unsigned ring_fill, ring_head;
  logic [31:0] next_seq;
  candle_t     expected_candles[$];

  assign pending = expected_candles.size();

  function automatic candle_t build_candle(logic [31:0] win, logic [1:0] kind,
                                           bit with_mean);
    candle_t     c;
    int unsigned idx;
    longint      dt;
    logic [31:0] t0, p, start;
    logic [33:0] vol;
    logic [127:0] acc;
    int unsigned cnt;
    t0  = ring_time[ring_head];
    p   = ring_price[ring_head];
    c.open_price = p;
    c.high_price = p;
    c.low_price  = p;
    vol = ring_qty[ring_head];
    acc = 128'(p) * 128'(ring_qty[ring_head]);
    cnt = 1;
    for (int unsigned k = 1; k < ring_fill; k++) begin
      idx = (ring_head + swoc_pkg::HISTORY_DEPTH - k) % swoc_pkg::HISTORY_DEPTH;
      dt  = longint'({32'd0, t0}) - longint'({32'd0, ring_time[idx]});
      if (dt > longint'({32'd0, win})) break;
      cnt++;
      p = ring_price[idx];
      if (p > c.high_price) c.high_price = p;
      if (p < c.low_price) c.low_price = p;
      c.open_price = p;
      vol += 34'(ring_qty[idx]);
      acc += 128'(p) * 128'(ring_qty[idx]);
    end
    start = next_seq - 32'(cnt - 1);
    c.which_window = kind;
    c.close_price  = ring_price[ring_head];
    c.close_stamp  = t0;
    c.volume       = vol;
    c.trade_count  = 11'(cnt);
    if (with_mean && vol != 0) begin
      c.mean_price = 32'((acc + 128'(vol >> 1)) / 128'(vol));
      c.mean_valid = 1'b1;
    end else begin
      c.mean_price = '0;
      c.mean_valid = 1'b0;
    end
    c.prior_sequence = (start == 0) ? -33'sd1 : $signed({1'b0, start - 32'd1});
    c.is_last = 1'b0;
    return c;
  endfunction

  always @(posedge clk) begin
    candle_t got, exp_c;
    int bad;
    if (rst) begin
      win_main <= 32'd60;
      win_gain <= '0;
      win_loss <= '0;
      ring_fill = 0;
      ring_head = 0;
      next_seq  = '0;
      fail_count <= 0;
      trades_seen <= 0;
      candles_seen <= 0;
      expected_candles.delete();
    end else begin
      if (write_enable) begin
        case (write_index)
          swoc_pkg::REG_MAIN_WINDOW: win_main <= write_data;
          swoc_pkg::REG_GAIN_WINDOW: win_gain <= write_data;
          swoc_pkg::REG_LOSS_WINDOW: win_loss <= write_data;
          default: ;
        endcase
      end
      if (trade.valid && trade.ready) begin
        ring_time[ring_head]  = trade.trade_time;
        ring_price[ring_head] = trade.trade_price;
        ring_qty[ring_head]   = trade.trade_quantity;
        if (ring_fill < swoc_pkg::HISTORY_DEPTH) ring_fill++;
        expected_candles.push_back(build_candle(win_main, swoc_pkg::WIN_MAIN, 1'b1));
        if (win_gain != 0)
          expected_candles.push_back(build_candle(win_gain, swoc_pkg::WIN_GAIN, 1'b1));
        if (win_loss != 0)
          expected_candles.push_back(build_candle(win_loss, swoc_pkg::WIN_LOSS, 1'b0));
        expected_candles[expected_candles.size() - 1].is_last = 1'b1;
        ring_head = (ring_head + 1) % swoc_pkg::HISTORY_DEPTH;
        next_seq  = next_seq + 32'd1;
        trades_seen <= trades_seen + 1;
      end
      if (candle.valid && candle.ready) begin
        candles_seen <= candles_seen + 1;
        if (expected_candles.size() == 0) begin
          $error("candle with no trade behind it");
          fail_count <= fail_count + 1;
        end else begin
          exp_c = expected_candles.pop_front();
          got.which_window   = candle.which_window;
          got.open_price     = candle.open_price;
          got.high_price     = candle.high_price;
          got.low_price      = candle.low_price;
          got.close_price    = candle.close_price;
          got.close_stamp    = candle.close_stamp;
          got.volume         = candle.volume;
          got.trade_count    = candle.trade_count;
          got.mean_price     = candle.mean_price;
          got.mean_valid     = candle.mean_valid;
          got.prior_sequence = candle.prior_sequence;
          got.is_last        = candle.is_last;
          bad = 0;
          if (got.which_window !== exp_c.which_window) begin
            $error("which_window exp %0d got %0d", exp_c.which_window, got.which_window);
            bad++;
          end
          if (got.open_price !== exp_c.open_price) begin
            $error("open_price exp %0d got %0d", exp_c.open_price, got.open_price);
            bad++;
          end
          if (got.high_price !== exp_c.high_price) begin
            $error("high_price exp %0d got %0d", exp_c.high_price, got.high_price);
            bad++;
          end
          if (got.low_price !== exp_c.low_price) begin
            $error("low_price exp %0d got %0d", exp_c.low_price, got.low_price);
            bad++;
          end
          if (got.close_price !== exp_c.close_price) begin
            $error("close_price exp %0d got %0d", exp_c.close_price, got.close_price);
            bad++;
          end
          if (got.close_stamp !== exp_c.close_stamp) begin
            $error("close_stamp exp %0d got %0d", exp_c.close_stamp, got.close_stamp);
            bad++;
          end
          if (got.volume !== exp_c.volume) begin
            $error("volume exp %0d got %0d", exp_c.volume, got.volume);
            bad++;
          end
          if (got.trade_count !== exp_c.trade_count) begin
            $error("trade_count exp %0d got %0d", exp_c.trade_count, got.trade_count);
            bad++;
          end
          if (got.mean_price !== exp_c.mean_price) begin
            $error("mean_price exp %0d got %0d", exp_c.mean_price, got.mean_price);
            bad++;
          end
          if (got.mean_valid !== exp_c.mean_valid) begin
            $error("mean_valid exp %0d got %0d", exp_c.mean_valid, got.mean_valid);
            bad++;
          end
          if (got.prior_sequence !== exp_c.prior_sequence) begin
            $error("prior_sequence exp %0d got %0d", exp_c.prior_sequence,
                   got.prior_sequence);
            bad++;
          end
          if (got.is_last !== exp_c.is_last) begin
            $error("is_last exp %0d got %0d", exp_c.is_last, got.is_last);
            bad++;
          end
          if (bad != 0) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives trades and window settings into the candle unit; a checker beside it
// predicts and compares every candle, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT = 40000;

  logic        clk;
  logic        rst;
  logic        write_enable;
  logic [1:0]  write_index;
  logic [31:0] write_data;
  int          fail_count, pending, trades_seen, candles_seen;
  int          send_gap_pct, sink_stall_pct;
  int          idle_cycles;
  logic [31:0] now_t;

  trade_if  trade ();
  candle_if candle ();

  sliding_window_ohlc_candle dut (
    .clk(clk), .rst(rst), .trade(trade), .candle(candle),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data)
  );

  candle_checker chk (
    .clk(clk), .rst(rst), .trade(trade), .candle(candle),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .fail_count(fail_count), .pending(pending),
    .trades_seen(trades_seen), .candles_seen(candles_seen)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Receiver: stall at random with the current percentage.
  always @(posedge clk) begin
    candle.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: count cycles with no request moving on either channel.
  always @(posedge clk) begin
    if (rst || (trade.valid && trade.ready) || (candle.valid && candle.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one trade request; hold it until the unit takes it.
  task automatic send_trade(logic [31:0] t, logic [31:0] p, logic [23:0] q);
    while ($urandom_range(99) < send_gap_pct) begin
      trade.valid <= 1'b0;
      @(posedge clk);
    end
    trade.valid          <= 1'b1;
    trade.trade_time     <= t;
    trade.trade_price    <= p;
    trade.trade_quantity <= q;
    @(posedge clk);
    while (!trade.ready) @(posedge clk);
  endtask

  // Drain all candles, then write the three window registers while idle.
  task automatic set_windows(logic [31:0] wm, logic [31:0] wg, logic [31:0] wl);
    trade.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_enable <= 1'b1;
    write_index  <= swoc_pkg::REG_MAIN_WINDOW;
    write_data   <= wm;
    @(posedge clk);
    write_index  <= swoc_pkg::REG_GAIN_WINDOW;
    write_data   <= wg;
    @(posedge clk);
    write_index  <= swoc_pkg::REG_LOSS_WINDOW;
    write_data   <= wl;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // Random trades: mostly small steps in time, sometimes big jumps,
  // rarely a step back.
  task automatic random_trades(int n);
    logic [31:0] p;
    logic [23:0] q;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 70) now_t += $urandom_range(6);
      else if (sel < 90) now_t += $urandom_range(200);
      else if (sel < 95) now_t += $urandom;
      else now_t -= $urandom_range(30);
      case ($urandom_range(3))
        0: p = $urandom;
        1: p = 32'd1000000 + $urandom_range(5000);
        2: p = ($urandom_range(1)) ? 32'hFFFF_FFFF - $urandom_range(9) : $urandom_range(9);
        default: p = 32'd42_0000 + $urandom_range(100000);
      endcase
      case ($urandom_range(3))
        0: q = 24'($urandom);
        1: q = 24'($urandom_range(100));
        2: q = ($urandom_range(1)) ? 24'hFFFFFF : 24'd0;
        default: q = 24'($urandom_range(5000));
      endcase
      send_trade(now_t, p, q);
      if (i == n / 2 && n > 10) begin
        // pause until the unit has nothing left to report
        trade.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    trade.valid = 1'b0;
    trade.trade_time = '0;
    trade.trade_price = '0;
    trade.trade_quantity = '0;
    candle.ready = 1'b0;
    write_enable = 1'b0;
    write_index = swoc_pkg::REG_MAIN_WINDOW;
    write_data = '0;
    send_gap_pct = 6;
    sink_stall_pct = 63;
    now_t = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset windows, extremes of price and quantity.
    send_trade(32'd0, 32'd0, 24'd0);
    send_trade(32'd10, 32'hFFFF_FFFF, 24'hFFFFFF);
    send_trade(32'd20, 32'd12345, 24'd1);
    send_trade(32'd70, 32'd1, 24'hFFFFFF);
    set_windows(32'd0, 32'd5, 32'd3);
    // zero total quantity in a one-trade window
    send_trade(32'd500, 32'd77, 24'd0);
    send_trade(32'd502, 32'd88, 24'd0);
    send_trade(32'd503, 32'hFFFF_FFFF, 24'd3);
    // stored time later than the newest one
    send_trade(32'd400, 32'd99, 24'd7);
    send_trade(32'd401, 32'd5, 24'd9);
    set_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_trade(32'hFFFF_FFF0, 32'hAAAA_AAAA, 24'h555555);
    send_trade(32'hFFFF_FFFF, 32'h5555_5555, 24'hAAAAAA);
    send_trade(32'hFFFF_FFFF, 32'd0, 24'hFFFFFF);
    set_windows(32'd1, 32'd0, 32'd2);
    send_trade(32'hFFFF_FFFF, 32'd3, 24'd2);
    send_trade(32'd0, 32'd4, 24'd3);

    // Random phases with varied window settings.
    now_t = 32'd1000;
    set_windows(32'd60, 32'd10, 32'd0);
    random_trades(40);
    set_windows(32'd30, 32'd0, 32'd300);
    random_trades(35);
    send_gap_pct = 63;
    sink_stall_pct = 6;
    now_t = 32'h8000_0000 + $urandom_range(1000);
    set_windows(32'd0, 32'd1, 32'd100);
    random_trades(35);
    set_windows(32'hFFFF_FFFF, 32'd20, 32'd5);
    random_trades(40);
    send_gap_pct = 0;
    sink_stall_pct = 0;
    now_t = 32'hFFFF_F000;
    set_windows(32'd100, 32'hFFFF_FFFF, 32'd1);
    random_trades(35);
    set_windows(32'd8, 32'd40, 32'd0);
    random_trades(35);

    trade.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);

    $display("Covered %0d trades and %0d candles over main, gain and loss windows,",
             trades_seen, candles_seen);
    $display("zero, unit and full-range window lengths, under three idling patterns.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
